FILE: design/tbcq_pkg.sv
// package for the timestamp bucket change queue
// holds sizes, result codes and the controller/datapath command and status structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tbcq_pkg;

  localparam int unsigned CAPACITY = 64;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned HandleW = 16;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_RELEASED = 2'd2,
    ST_NONE     = 2'd3
  } status_e;

  typedef enum logic {
    ACT_INSERT  = 1'b0,
    ACT_RELEASE = 1'b1
  } action_e;

  // controller to datapath
  typedef struct packed {
    logic insert;
    logic pop;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_empty;
    logic is_full;
    logic head_le_limit;
    logic head_matches_next;
  } sts_t;

endpackage

`default_nettype wire

FILE: design/tbcq_if.sv
// handshake channels of the timestamp bucket change queue
// request channel and response channel, each with source and sink modports
// depends on tbcq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tbcq_req_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [tbcq_pkg::TimeW-1:0]   change_time;
  logic [tbcq_pkg::HandleW-1:0] change_handle;
  logic [tbcq_pkg::TimeW-1:0]   release_limit;

  modport source (output valid, action, change_time, change_handle, release_limit,
                  input ready);
  modport sink (input valid, action, change_time, change_handle, release_limit,
                output ready);
endinterface

interface tbcq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [tbcq_pkg::TimeW-1:0]   out_time;
  logic [tbcq_pkg::HandleW-1:0] out_handle;
  logic                         last;

  modport source (output valid, status, out_time, out_handle, last, input ready);
  modport sink (input valid, status, out_time, out_handle, last, output ready);
endinterface

`default_nettype wire

FILE: design/tbcq_datapath.sv
// sorted cell row of the change queue: shift-insert and pop from the head
// cells are kept in ascending timestamp order, the count tracks valid cells
// depends on tbcq_pkg
`timescale 1ns / 1ps
`default_nettype none

module tbcq_datapath #(
  parameter int unsigned Capacity = tbcq_pkg::CAPACITY
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tbcq_pkg::cmd_t               cmd_i,
  input  wire logic [tbcq_pkg::TimeW-1:0]   time_i,
  input  wire logic [tbcq_pkg::HandleW-1:0] handle_i,
  input  wire logic [tbcq_pkg::TimeW-1:0]   limit_i,
  output tbcq_pkg::sts_t                    sts_o,
  output logic [tbcq_pkg::TimeW-1:0]        head_time_o,
  output logic [tbcq_pkg::HandleW-1:0]      head_handle_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);

  logic [CntW-1:0]                  count_q, count_d;
  logic [tbcq_pkg::TimeW-1:0]       times_q   [Capacity];
  logic [tbcq_pkg::HandleW-1:0]     handles_q [Capacity];
  logic [Capacity-1:0]              lt;

  // cells strictly earlier than the new timestamp stay put; this is a prefix
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    assign lt[i] = (CntW'(i) < count_q) && (times_q[i] < time_i);

    always_ff @(posedge clk_i) begin
      if (cmd_i.insert) begin
        if (!lt[i]) begin
          if (i == 0) begin
            times_q[i]   <= time_i;
            handles_q[i] <= handle_i;
          end else if (lt[(i == 0) ? 0 : i - 1]) begin
            times_q[i]   <= time_i;
            handles_q[i] <= handle_i;
          end else begin
            times_q[i]   <= times_q[(i == 0) ? 0 : i - 1];
            handles_q[i] <= handles_q[(i == 0) ? 0 : i - 1];
          end
        end
      end else if (cmd_i.pop && (i < Capacity - 1)) begin
        times_q[i]   <= times_q[(i < Capacity - 1) ? i + 1 : i];
        handles_q[i] <= handles_q[(i < Capacity - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign sts_o.is_empty          = (count_q == '0);
  assign sts_o.is_full           = (count_q == CntW'(Capacity));
  assign sts_o.head_le_limit     = (times_q[0] <= limit_i);
  assign sts_o.head_matches_next = (count_q >= CntW'(2)) && (times_q[1] == times_q[0]);
  assign head_time_o             = times_q[0];
  assign head_handle_o           = handles_q[0];

endmodule

`default_nettype wire

FILE: design/tbcq_ctrl.sv
// controller of the change queue: request decode, release run sequencing and
// the registered response beat
// depends on tbcq_pkg
`timescale 1ns / 1ps
`default_nettype none

module tbcq_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         req_valid_i,
  input  wire logic                         req_action_i,
  output logic                              req_ready_o,
  input  wire logic                         rsp_ready_i,
  output logic                              rsp_valid_o,
  output logic [1:0]                        rsp_status_o,
  output logic [tbcq_pkg::TimeW-1:0]        rsp_time_o,
  output logic [tbcq_pkg::HandleW-1:0]      rsp_handle_o,
  output logic                              rsp_last_o,
  input  wire tbcq_pkg::sts_t               sts_i,
  input  wire logic [tbcq_pkg::TimeW-1:0]   head_time_i,
  input  wire logic [tbcq_pkg::HandleW-1:0] head_handle_i,
  output tbcq_pkg::cmd_t                    cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e state_q;
  logic   can_load;
  logic   req_fire;
  logic   is_insert;
  logic   beat_load;

  // output slot is free now or drains this cycle
  assign can_load    = !rsp_valid_o || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE) && can_load;
  assign req_fire    = req_valid_i && req_ready_o;
  assign is_insert   = (req_action_i == tbcq_pkg::ACT_INSERT);

  // a new beat enters the output register this cycle
  assign beat_load = (state_q == S_RUN) ? can_load :
                     (req_fire && (is_insert || sts_i.is_empty || !sts_i.head_le_limit));

  assign cmd_o.insert = req_fire && is_insert && !sts_i.is_full;
  assign cmd_o.pop    = (state_q == S_RUN) && can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rsp_valid_o  <= 1'b0;
      rsp_status_o <= tbcq_pkg::ST_INSERTED;
      rsp_time_o   <= '0;
      rsp_handle_o <= '0;
      rsp_last_o   <= 1'b0;
    end else begin
      if (beat_load) begin
        rsp_valid_o <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            if (is_insert) begin
              rsp_status_o <= sts_i.is_full ? tbcq_pkg::ST_FULL : tbcq_pkg::ST_INSERTED;
              rsp_time_o   <= '0;
              rsp_handle_o <= '0;
              rsp_last_o   <= 1'b1;
            end else if (sts_i.is_empty || !sts_i.head_le_limit) begin
              rsp_status_o <= tbcq_pkg::ST_NONE;
              rsp_time_o   <= '0;
              rsp_handle_o <= '0;
              rsp_last_o   <= 1'b1;
            end else begin
              state_q <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (can_load) begin
            rsp_status_o <= tbcq_pkg::ST_RELEASED;
            rsp_time_o   <= head_time_i;
            rsp_handle_o <= head_handle_i;
            rsp_last_o   <= !sts_i.head_matches_next;
            if (!sts_i.head_matches_next) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_no_insert_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.insert |-> !sts_i.is_full)
    else $error("insert into full store");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |-> !sts_i.is_empty)
    else $error("pop from empty store");

  a_run_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> !sts_i.is_empty)
    else $error("release run on empty store");

  a_run_beat_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |=> (rsp_valid_o && (rsp_status_o == tbcq_pkg::ST_RELEASED)))
    else $error("popped entry not presented");

  a_ends_idle_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.pop && !sts_i.head_matches_next) |=> (state_q == S_IDLE) && rsp_last_o)
    else $error("run did not end on last beat");

endmodule

`default_nettype wire

FILE: design/timestamp_bucket_change_queue_core.sv
// top level of the timestamp bucket change queue
// joins the controller and the sorted cell datapath to the request/response channels
// depends on tbcq_pkg, tbcq_if, tbcq_ctrl, tbcq_datapath
`timescale 1ns / 1ps
`default_nettype none

// Holds up to Capacity pending changes in ascending timestamp order in a row
// of shift cells; an insert into a store that is not full lands ahead of all
// equal or later timestamps in the cycle it is accepted, so an insert (or a
// release that finds nothing ready) gives its single response beat on the next
// cycle and a new request can be taken every cycle while the response side
// keeps up. A release whose head is due pops the head cell once per cycle while
// the response side keeps up, one beat per cell, for the group of equal
// timestamps at the head. Requests are held off while a release run is being emitted.
module timestamp_bucket_change_queue_core #(
  parameter int unsigned Capacity = tbcq_pkg::CAPACITY
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tbcq_req_if.sink    req_i,
  tbcq_rsp_if.source  rsp_o
);

  tbcq_pkg::cmd_t                 cmd;
  tbcq_pkg::sts_t                 sts;
  logic [tbcq_pkg::TimeW-1:0]     head_time;
  logic [tbcq_pkg::HandleW-1:0]   head_handle;

  tbcq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_action_i  (req_i.action),
    .req_ready_o   (req_i.ready),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_status_o  (rsp_o.status),
    .rsp_time_o    (rsp_o.out_time),
    .rsp_handle_o  (rsp_o.out_handle),
    .rsp_last_o    (rsp_o.last),
    .sts_i         (sts),
    .head_time_i   (head_time),
    .head_handle_i (head_handle),
    .cmd_o         (cmd)
  );

  tbcq_datapath #(
    .Capacity (Capacity)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .time_i        (req_i.change_time),
    .handle_i      (req_i.change_handle),
    .limit_i       (req_i.release_limit),
    .sts_o         (sts),
    .head_time_o   (head_time),
    .head_handle_o (head_handle)
  );

endmodule

`default_nettype wire
